### design/itra_pkg.sv
// shared types, constants and the digit character lookup for the radix ascii unit
package itra_pkg;

    localparam int IN_VALUE_BITS = 32;
    localparam int BASE_BITS     = 5;
    localparam int FLAG_BITS     = 2;
    localparam int DIGIT_BITS    = 4;
    localparam int CHAR_BITS     = 7;

    // format flag bit positions
    localparam int FLAG_UNSIGNED = 0;
    localparam int FLAG_LOWER    = 1;

    localparam logic [BASE_BITS-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX = 5'd16;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 7'h61;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic [IN_VALUE_BITS-1:0] value;
        logic [BASE_BITS-1:0]     base;
        logic [FLAG_BITS-1:0]     format_flags;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEGATE,
        ST_DIVIDE,
        ST_READ,
        ST_EMIT
    } state_t;

    // digit 0..15 to its ascii character
    function automatic logic [CHAR_BITS-1:0] digit_char(
        input logic [DIGIT_BITS-1:0] digit,
        input logic                  lower
    );
        logic [CHAR_BITS-1:0] letter_base;
        letter_base = lower ? CHAR_LOWER : CHAR_UPPER;
        if (digit < DIGIT_TEN)
        begin
            return CHAR_ZERO + CHAR_BITS'(digit);
        end
        return letter_base + CHAR_BITS'(digit - DIGIT_TEN);
    endfunction

endpackage

### design/itra_digit_stack.sv
// digit stack memory with one write port and a registered read port
module itra_digit_stack #(
    parameter int DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic [itra_pkg::DIGIT_BITS-1:0]   wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic [itra_pkg::DIGIT_BITS-1:0]   rd_data
);

    logic [itra_pkg::DIGIT_BITS-1:0] mem [DEPTH];
    logic [itra_pkg::DIGIT_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/integer_to_radix_ascii_unit.sv
// top level: integer to radix ascii text converter with a bit-serial divider
//
//   channel   signals                        direction   handshake
//   request   start, busy, request           in          taken when start && !busy
//   result    strobe, result                 out         one cycle per character, no stall
//
// operation:
//   the restoring divider yields one quotient bit per cycle, one full pass over the value per digit
//   a negative signed value first goes through a bit-serial two's complement pass
//   characters leave on consecutive cycles; busy drops as the last one is shown
//   reset returns to idle and clears the strobe; the stack needs no clearing
module integer_to_radix_ascii_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  itra_pkg::in_item_t  request,
    output logic                strobe,
    output itra_pkg::out_item_t result
);

    localparam int CW = $clog2(VALUE_BITS);      // bit counter and stack address
    localparam int NW = $clog2(VALUE_BITS + 1);  // digit count, holds VALUE_BITS
    localparam int BB = itra_pkg::BASE_BITS;
    localparam int DB = itra_pkg::DIGIT_BITS;

    itra_pkg::state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] shift_reg, shift_next;   // magnitude, then quotient
    logic [BB-1:0]         rem_reg, rem_next;       // partial remainder
    logic [BB-1:0]         base_reg, base_next;
    logic                  carry_reg, carry_next;   // negate carry
    logic                  nz_reg, nz_next;         // quotient has a set bit
    logic [CW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [NW-1:0]         dig_cnt_reg, dig_cnt_next;
    logic                  neg_reg, neg_next;
    logic                  lower_reg, lower_next;
    logic                  strobe_reg, strobe_next;
    itra_pkg::out_item_t   result_reg, result_next;

    // input value zero extended or truncated to the working width
    logic [VALUE_BITS+itra_pkg::IN_VALUE_BITS-1:0] value_wide;
    logic [VALUE_BITS-1:0]                         value_ext;
    logic [BB-1:0]                                 base_clamped;

    // divider step
    logic [BB-1:0] rem_shift;
    logic          quot_bit;
    logic [BB-1:0] rem_step;
    logic          bit_last;
    logic [NW-1:0] dig_cnt_dec;

    // stack port
    logic          wr_en;
    logic          rd_en;
    logic [DB-1:0] rd_data;

    assign value_wide = {{VALUE_BITS{1'b0}}, request.value};
    assign value_ext  = value_wide[VALUE_BITS-1:0];

    always_comb
    begin
        if (request.base < itra_pkg::BASE_MIN)
        begin
            base_clamped = itra_pkg::BASE_MIN;
        end
        else if (request.base > itra_pkg::BASE_MAX)
        begin
            base_clamped = itra_pkg::BASE_MAX;
        end
        else
        begin
            base_clamped = request.base;
        end
    end

    // restoring division: bring in the next dividend bit, subtract base if it fits
    assign rem_shift   = {rem_reg[BB-2:0], shift_reg[VALUE_BITS-1]};
    assign quot_bit    = (rem_shift >= base_reg);
    assign rem_step    = quot_bit ? (rem_shift - base_reg) : rem_shift;
    assign bit_last    = (bit_cnt_reg == CW'(VALUE_BITS - 1));
    assign dig_cnt_dec = dig_cnt_reg - NW'(1);

    itra_digit_stack #(
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (dig_cnt_reg[CW-1:0]),
        .wr_data (rem_step[DB-1:0]),
        .rd_en   (rd_en),
        .rd_addr (dig_cnt_dec[CW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itra_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        base_reg    <= base_next;
        carry_reg   <= carry_next;
        nz_reg      <= nz_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        lower_reg   <= lower_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        base_next    = base_reg;
        carry_next   = carry_reg;
        nz_next      = nz_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        lower_next   = lower_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        case (state_reg)
            itra_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    shift_next   = value_ext;
                    neg_next     = !request.format_flags[itra_pkg::FLAG_UNSIGNED]
                                   && value_ext[VALUE_BITS-1];
                    lower_next   = request.format_flags[itra_pkg::FLAG_LOWER];
                    base_next    = base_clamped;
                    rem_next     = '0;
                    nz_next      = 1'b0;
                    carry_next   = 1'b1;
                    bit_cnt_next = '0;
                    dig_cnt_next = '0;
                    if (!request.format_flags[itra_pkg::FLAG_UNSIGNED]
                        && value_ext[VALUE_BITS-1])
                    begin
                        state_next = itra_pkg::ST_NEGATE;
                    end
                    else
                    begin
                        state_next = itra_pkg::ST_DIVIDE;
                    end
                end
            end

            itra_pkg::ST_NEGATE:
            begin
                // invert and add one, lsb first, rotating right
                shift_next = {~shift_reg[0] ^ carry_reg, shift_reg[VALUE_BITS-1:1]};
                carry_next = ~shift_reg[0] & carry_reg;
                if (bit_last)
                begin
                    bit_cnt_next = '0;
                    state_next   = itra_pkg::ST_DIVIDE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + CW'(1);
                end
            end

            itra_pkg::ST_DIVIDE:
            begin
                shift_next = {shift_reg[VALUE_BITS-2:0], quot_bit};
                rem_next   = rem_step;
                nz_next    = nz_reg | quot_bit;
                if (bit_last)
                begin
                    // remainder is the digit, quotient stays for the next pass
                    wr_en        = 1'b1;
                    dig_cnt_next = dig_cnt_reg + NW'(1);
                    rem_next     = '0;
                    nz_next      = 1'b0;
                    bit_cnt_next = '0;
                    if (!(nz_reg | quot_bit))
                    begin
                        state_next = itra_pkg::ST_READ;
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + CW'(1);
                end
            end

            itra_pkg::ST_READ:
            begin
                // fetch the top digit, show the sign meanwhile
                rd_en        = 1'b1;
                dig_cnt_next = dig_cnt_dec;
                if (neg_reg)
                begin
                    strobe_next           = 1'b1;
                    result_next.character = itra_pkg::CHAR_MINUS;
                    result_next.last      = 1'b0;
                end
                state_next = itra_pkg::ST_EMIT;
            end

            itra_pkg::ST_EMIT:
            begin
                strobe_next           = 1'b1;
                result_next.character = itra_pkg::digit_char(rd_data, lower_reg);
                result_next.last      = (dig_cnt_reg == '0);
                if (dig_cnt_reg != '0)
                begin
                    rd_en        = 1'b1;
                    dig_cnt_next = dig_cnt_dec;
                end
                else
                begin
                    state_next = itra_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = itra_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != itra_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

### design/itra_checker.sv
// port level checks for the radix ascii unit, bound to the top level
module itra_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input itra_pkg::in_item_t  request,
    input logic                strobe,
    input itra_pkg::out_item_t result
);

    // an accepted item keeps the unit busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // nothing comes out the cycle after an accept
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("character right after accept");

    // characters of one number come back to back
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("gap inside a number");

    // the final character ends the item and frees the unit
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |-> !busy)
        else $error("still busy on final character");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("character after final character");

endmodule

bind integer_to_radix_ascii_unit itra_checker u_itra_checker (.*);
